@@ sv/segment_circle_intersect_top_defines.svh @@
// assertion macros for the segment circle intersect block
// used by segment_circle_intersect_top.sv, no other dependencies
`ifndef SEGMENT_CIRCLE_INTERSECT_TOP_DEFINES_SVH
`define SEGMENT_CIRCLE_INTERSECT_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define SCI_ASSERT_IMPLIES(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("sci assertion failed");
`define SCI_ASSERT_DELAYED(lbl, clk_s, rstn_s, ante, dly, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> ##dly (cons)) \
        else $error("sci assertion failed");
`else
`define SCI_ASSERT_IMPLIES(lbl, clk_s, rstn_s, ante, cons)
`define SCI_ASSERT_DELAYED(lbl, clk_s, rstn_s, ante, dly, cons)
`endif
`endif

@@ sv/sci_pkg.sv @@
// shared constants for the segment circle intersect block
// no dependencies
`default_nettype none
package sci_pkg;
    typedef logic [1:0] hit_kind_t;

    localparam hit_kind_t KIND_NONE     = 2'd0;
    localparam hit_kind_t KIND_ENDPOINT = 2'd1;
    localparam hit_kind_t KIND_NEAREST  = 2'd2;

    localparam int TOL_WIDTH  = 16;
    localparam int PIPE_DEPTH = 7;
endpackage
`default_nettype wire

@@ sv/segment_circle_intersect_top.sv @@
// segment circle intersect: seven-stage pipeline, exact squared-length compares
// depends on sci_pkg and segment_circle_intersect_top_defines.svh
// throughput: one test per cycle, busy is always low, no stall from the receiver
// the widest path is the split square of the projection offset (stages 5 and 6)
// reset: clears the valid pipe and loads tol_reg with 0.1 in fixed point
`default_nettype none
`include "segment_circle_intersect_top_defines.svh"
module segment_circle_intersect_top
    import sci_pkg::*;
#(
    parameter int COORD_WIDTH = 24,
    parameter int FRAC_BITS   = 8
)
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          start,
    output logic                         busy,
    input  wire signed [COORD_WIDTH-1:0] seg_start_x,
    input  wire signed [COORD_WIDTH-1:0] seg_start_y,
    input  wire signed [COORD_WIDTH-1:0] seg_end_x,
    input  wire signed [COORD_WIDTH-1:0] seg_end_y,
    input  wire signed [COORD_WIDTH-1:0] centre_x,
    input  wire signed [COORD_WIDTH-1:0] centre_y,
    input  wire        [COORD_WIDTH-2:0] radius,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire        [TOL_WIDTH-1:0]   cfg_data,
    output logic                         done,
    output logic       [1:0]             hit_kind
);
    localparam int D   = COORD_WIDTH + 1;
    localparam int P   = 2 * D;
    localparam int S   = P + 1;
    localparam int M   = S;
    localparam int H   = (M + 1) / 2;
    localparam int HL  = M - H;
    localparam int RW  = COORD_WIDTH - 1;
    localparam int R2W = 2 * RW;
    localparam int G   = (R2W + 1) / 2;
    localparam int GL  = R2W - G;
    localparam int T2W = 2 * TOL_WIDTH;
    localparam int CW  = 2 * M + 2;
    localparam logic [TOL_WIDTH-1:0] TOL_RESET = TOL_WIDTH'(((1 << FRAC_BITS) + 5) / 10);

    logic accept;
    assign accept    = start && !busy;
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    logic [TOL_WIDTH-1:0] tol_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            tol_reg <= cfg_data;
        end
    end

    // valid pipe, one bit per stage
    logic [PIPE_DEPTH-1:0] v_reg;
    logic [PIPE_DEPTH-1:0] v_next;
    assign v_next = {v_reg[PIPE_DEPTH-2:0], accept};
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    // stage 1: differences
    logic signed [D-1:0] acx_next, acy_next, bcx_next, bcy_next, ux_next, uy_next;
    logic signed [D-1:0] acx_reg, acy_reg, bcx_reg, bcy_reg, ux_reg, uy_reg;
    logic [RW-1:0] r1_reg;
    assign acx_next = D'(seg_start_x) - D'(centre_x);
    assign acy_next = D'(seg_start_y) - D'(centre_y);
    assign bcx_next = D'(seg_end_x) - D'(centre_x);
    assign bcy_next = D'(seg_end_y) - D'(centre_y);
    assign ux_next  = D'(seg_end_x) - D'(seg_start_x);
    assign uy_next  = D'(seg_end_y) - D'(seg_start_y);
    always_ff @(posedge clk)
    begin
        acx_reg <= acx_next;
        acy_reg <= acy_next;
        bcx_reg <= bcx_next;
        bcy_reg <= bcy_next;
        ux_reg  <= ux_next;
        uy_reg  <= uy_next;
        r1_reg  <= radius;
    end

    // stage 2: products
    logic signed [P-1:0] pax_reg, pay_reg, pbx_reg, pby_reg, pux_reg, puy_reg;
    logic signed [P-1:0] qax_reg, qay_reg, qbx_reg, qby_reg, cxa_reg, cxb_reg;
    logic [R2W-1:0] r2_2_reg;
    logic zero2_reg;
    logic signed [P-1:0] pax_next, pay_next, pbx_next, pby_next, pux_next, puy_next;
    logic signed [P-1:0] qax_next, qay_next, qbx_next, qby_next, cxa_next, cxb_next;
    logic [R2W-1:0] r2_2_next;
    logic zero2_next;
    assign pax_next   = acx_reg * acx_reg;
    assign pay_next   = acy_reg * acy_reg;
    assign pbx_next   = bcx_reg * bcx_reg;
    assign pby_next   = bcy_reg * bcy_reg;
    assign pux_next   = ux_reg * ux_reg;
    assign puy_next   = uy_reg * uy_reg;
    assign qax_next   = acx_reg * ux_reg;
    assign qay_next   = acy_reg * uy_reg;
    assign qbx_next   = bcx_reg * ux_reg;
    assign qby_next   = bcy_reg * uy_reg;
    assign cxa_next   = acy_reg * ux_reg;
    assign cxb_next   = acx_reg * uy_reg;
    assign r2_2_next  = r1_reg * r1_reg;
    assign zero2_next = (ux_reg == '0) && (uy_reg == '0);
    always_ff @(posedge clk)
    begin
        pax_reg   <= pax_next;
        pay_reg   <= pay_next;
        pbx_reg   <= pbx_next;
        pby_reg   <= pby_next;
        pux_reg   <= pux_next;
        puy_reg   <= puy_next;
        qax_reg   <= qax_next;
        qay_reg   <= qay_next;
        qbx_reg   <= qbx_next;
        qby_reg   <= qby_next;
        cxa_reg   <= cxa_next;
        cxb_reg   <= cxb_next;
        r2_2_reg  <= r2_2_next;
        zero2_reg <= zero2_next;
    end

    // stage 3: dot products, endpoint test
    // nd1 is minus d1 (centre beyond start), nd2 is minus d2 (centre beyond end)
    logic signed [S-1:0] da_next, db_next, l2_next, nd1_next, nd2_next, cr_next;
    logic signed [S-1:0] l2_3_reg, nd1_reg, nd2_reg, cr_reg;
    logic hit3_next, hit3_reg, zero3_reg;
    logic [R2W-1:0] r2_3_reg;
    assign da_next   = S'(pax_reg) + S'(pay_reg);
    assign db_next   = S'(pbx_reg) + S'(pby_reg);
    assign l2_next   = S'(pux_reg) + S'(puy_reg);
    assign nd1_next  = S'(qax_reg) + S'(qay_reg);
    assign nd2_next  = S'(qbx_reg) + S'(qby_reg);
    assign cr_next   = S'(cxa_reg) - S'(cxb_reg);
    assign hit3_next = ($unsigned(da_next) < S'(r2_2_reg))
                    || ($unsigned(db_next) < S'(r2_2_reg));
    always_ff @(posedge clk)
    begin
        l2_3_reg  <= l2_next;
        nd1_reg   <= nd1_next;
        nd2_reg   <= nd2_next;
        cr_reg    <= cr_next;
        hit3_reg  <= hit3_next;
        zero3_reg <= zero2_reg;
        r2_3_reg  <= r2_2_reg;
    end

    // stage 4: distance past the nearer end, magnitude of cross product
    logic [M-1:0] e_next, e_reg, cra_next, cra_reg, l2_4_reg;
    logic [T2W-1:0] tol2_next, tol2_reg;
    logic hit4_reg, zero4_reg;
    logic [R2W-1:0] r2_4_reg;
    always_comb
    begin
        if (!nd1_reg[S-1] && (nd1_reg != '0))
        begin
            e_next = $unsigned(nd1_reg);
        end
        else if (nd2_reg[S-1])
        begin
            e_next = $unsigned(-nd2_reg);
        end
        else
        begin
            e_next = '0;
        end
    end
    assign cra_next  = cr_reg[S-1] ? $unsigned(-cr_reg) : $unsigned(cr_reg);
    assign tol2_next = tol_reg * tol_reg;
    always_ff @(posedge clk)
    begin
        e_reg     <= e_next;
        cra_reg   <= cra_next;
        l2_4_reg  <= $unsigned(l2_3_reg);
        tol2_reg  <= tol2_next;
        hit4_reg  <= hit3_reg;
        zero4_reg <= zero3_reg;
        r2_4_reg  <= r2_3_reg;
    end

    // stage 5: partial products of the wide squares
    logic [H-1:0]  el, cl, ll;
    logic [HL-1:0] eh, ch, lh;
    logic [G-1:0]  rl;
    logic [GL-1:0] rh;
    assign el = e_reg[H-1:0];
    assign eh = e_reg[M-1:H];
    assign cl = cra_reg[H-1:0];
    assign ch = cra_reg[M-1:H];
    assign ll = l2_4_reg[H-1:0];
    assign lh = l2_4_reg[M-1:H];
    assign rl = r2_4_reg[G-1:0];
    assign rh = r2_4_reg[R2W-1:G];

    logic [2*H-1:0]    ell_next, cll_next, ell_reg, cll_reg;
    logic [H+HL-1:0]   elh_next, clh_next, elh_reg, clh_reg;
    logic [2*HL-1:0]   ehh_next, chh_next, ehh_reg, chh_reg;
    logic [T2W+H-1:0]  tl_next, tl_reg;
    logic [T2W+HL-1:0] th_next, th_reg;
    logic [G+H-1:0]    rll_next, rll_reg;
    logic [G+HL-1:0]   rlh_next, rlh_reg;
    logic [GL+H-1:0]   rhl_next, rhl_reg;
    logic [GL+HL-1:0]  rhh_next, rhh_reg;
    logic hit5_reg, zero5_reg;
    assign ell_next = el * el;
    assign elh_next = el * eh;
    assign ehh_next = eh * eh;
    assign cll_next = cl * cl;
    assign clh_next = cl * ch;
    assign chh_next = ch * ch;
    assign tl_next  = tol2_reg * ll;
    assign th_next  = tol2_reg * lh;
    assign rll_next = rl * ll;
    assign rlh_next = rl * lh;
    assign rhl_next = rh * ll;
    assign rhh_next = rh * lh;
    always_ff @(posedge clk)
    begin
        ell_reg   <= ell_next;
        elh_reg   <= elh_next;
        ehh_reg   <= ehh_next;
        cll_reg   <= cll_next;
        clh_reg   <= clh_next;
        chh_reg   <= chh_next;
        tl_reg    <= tl_next;
        th_reg    <= th_next;
        rll_reg   <= rll_next;
        rlh_reg   <= rlh_next;
        rhl_reg   <= rhl_next;
        rhh_reg   <= rhh_next;
        hit5_reg  <= hit4_reg;
        zero5_reg <= zero4_reg;
    end

    // stage 6: recombine, lhs is 4 * e^2
    logic [CW-1:0] lhs_next, rhs_next, c2_next, rl2_next;
    logic [CW-1:0] lhs_reg, rhs_reg, c2_reg, rl2_reg;
    logic hit6_reg, zero6_reg;
    assign lhs_next = ((CW'(ehh_reg) << (2 * H)) + (CW'(elh_reg) << (H + 1))
                    + CW'(ell_reg)) << 2;
    assign rhs_next = (CW'(th_reg) << H) + CW'(tl_reg);
    assign c2_next  = (CW'(chh_reg) << (2 * H)) + (CW'(clh_reg) << (H + 1))
                    + CW'(cll_reg);
    assign rl2_next = (CW'(rhh_reg) << (G + H)) + (CW'(rhl_reg) << G)
                    + (CW'(rlh_reg) << H) + CW'(rll_reg);
    always_ff @(posedge clk)
    begin
        lhs_reg   <= lhs_next;
        rhs_reg   <= rhs_next;
        c2_reg    <= c2_next;
        rl2_reg   <= rl2_next;
        hit6_reg  <= hit5_reg;
        zero6_reg <= zero5_reg;
    end

    // stage 7: decision
    hit_kind_t kind_next, kind_reg;
    logic zero7_reg;
    always_comb
    begin
        if (hit6_reg)
        begin
            kind_next = KIND_ENDPOINT;
        end
        else if (!zero6_reg && (lhs_reg <= rhs_reg) && (c2_reg <= rl2_reg))
        begin
            kind_next = KIND_NEAREST;
        end
        else
        begin
            kind_next = KIND_NONE;
        end
    end
    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        zero7_reg <= zero6_reg;
    end

    assign done     = v_reg[PIPE_DEPTH-1];
    assign hit_kind = kind_reg;

    `SCI_ASSERT_DELAYED(a_latency, clk, rst_n, accept, PIPE_DEPTH, done)
    `SCI_ASSERT_IMPLIES(a_no_spurious, clk, rst_n, done, $past(accept, PIPE_DEPTH))
    `SCI_ASSERT_IMPLIES(a_zero_len, clk, rst_n, done && zero7_reg, hit_kind != KIND_NEAREST)
endmodule
`default_nettype wire

@@ dv/segment_circle_intersect_top_tb.sv @@
// self-checking testbench for segment_circle_intersect_top: exact-arithmetic hit predictor,
// directed corner geometry plus random segment/circle queries, tolerance register sweeps
// depends on sci_pkg and segment_circle_intersect_top
`timescale 1ns / 1ps
module segment_circle_intersect_top_tb;
    import sci_pkg::*;

    localparam int CW = 24;
    localparam int LATENCY = 7;
    localparam int NUM_RANDOM = 1900;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic signed [CW-1:0] CMAX = 24'sh7fffff;
    localparam logic signed [CW-1:0] CMIN = -24'sh800000;
    localparam logic [CW-2:0] RMAX = 23'h7fffff;

    typedef struct packed {
        logic signed [CW-1:0] ax, ay, bx, by, cx, cy;
        logic [CW-2:0] r;
    } query_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [CW-1:0] seg_start_x = '0, seg_start_y = '0, seg_end_x = '0, seg_end_y = '0;
    logic signed [CW-1:0] centre_x = '0, centre_y = '0;
    logic [CW-2:0] radius = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [TOL_WIDTH-1:0] cfg_data = '0;
    logic done;
    logic [1:0] hit_kind;

    segment_circle_intersect_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .seg_start_x(seg_start_x), .seg_start_y(seg_start_y),
        .seg_end_x(seg_end_x), .seg_end_y(seg_end_y),
        .centre_x(centre_x), .centre_y(centre_y), .radius(radius),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .done(done), .hit_kind(hit_kind)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    query_t pending_queries[$];
    hit_kind_t expected_kinds[$];
    logic [TOL_WIDTH-1:0] tolerance;
    int errors = 0;
    int cycles = 0;
    int kind_seen[3] = '{0, 0, 0};
    bit hold_off = 1'b0;
    int burst_left = 0;
    int gap_left = 0;

    // exact decision in 160-bit signed arithmetic
    function automatic hit_kind_t predict_hit(query_t q, logic [TOL_WIDTH-1:0] tol);
        logic signed [159:0] ax, ay, bx, by, cx, cy, r, ux, uy;
        logic signed [159:0] r2, l2, d1, d2, e, cr, t;
        ax = q.ax; ay = q.ay; bx = q.bx; by = q.by; cx = q.cx; cy = q.cy;
        r = $signed({1'b0, q.r});
        t = $signed({1'b0, tol});
        ux = bx - ax;
        uy = by - ay;
        r2 = r * r;
        if ((ax - cx) * (ax - cx) + (ay - cy) * (ay - cy) < r2 ||
            (bx - cx) * (bx - cx) + (by - cy) * (by - cy) < r2)
            return KIND_ENDPOINT;
        if (ux == 0 && uy == 0)
            return KIND_NONE;
        l2 = ux * ux + uy * uy;
        d1 = (cx - ax) * ux + (cy - ay) * uy;
        d2 = (cx - bx) * ux + (cy - by) * uy;
        e = (d1 < 0) ? -d1 : ((d2 > 0) ? d2 : 0);
        if (4 * e * e > t * t * l2)
            return KIND_NONE;
        cr = (cx - ax) * uy - (cy - ay) * ux;
        return (cr * cr <= r2 * l2) ? KIND_NEAREST : KIND_NONE;
    endfunction

    // driver: bursts and gaps, one beat per accepted start
    always @(negedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && start && !busy)
        begin
            expected_kinds.push_back(predict_hit(pending_queries[0], tolerance));
            void'(pending_queries.pop_front());
        end
        if (rst_n && !hold_off && pending_queries.size() > 0)
        begin
            query_t q;
            q = pending_queries[0];
            if (gap_left > 0 && !(start && busy))
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else
            begin
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end
                else
                    burst_left <= burst_left - 1;
                start <= 1'b1;
                seg_start_x <= q.ax; seg_start_y <= q.ay;
                seg_end_x <= q.bx; seg_end_y <= q.by;
                centre_x <= q.cx; centre_y <= q.cy;
                radius <= q.r;
            end
        end
        else
            start <= 1'b0;
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_kinds.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0d", $time, hit_kind);
                errors++;
            end
            else
            begin
                if (hit_kind !== expected_kinds[0])
                begin
                    $display("%0t: hit_kind mismatch, expected %0d, actual %0d",
                             $time, expected_kinds[0], hit_kind);
                    errors++;
                end
                if (expected_kinds[0] <= KIND_NEAREST)
                    kind_seen[expected_kinds[0]]++;
                void'(expected_kinds.pop_front());
            end
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("segment_circle_intersect_top test failed");
            $finish;
        end
    end

    function automatic logic signed [CW-1:0] rand_coord(int span);
        case ($urandom_range(0, 3))
            0: return $signed(CW'($urandom()));
            1: return CW'(CMAX - $urandom_range(0, span));
            2: return CW'(CMIN + $urandom_range(0, span));
            default: return CW'($signed(CW'($urandom_range(0, 2 * span))) - span);
        endcase
    endfunction

    function automatic query_t random_query();
        query_t q;
        int span;
        logic signed [CW-1:0] tx, ty;
        span = ($urandom_range(0, 1) == 0) ? 4000 : 1000000;
        q.ax = rand_coord(span); q.ay = rand_coord(span);
        q.cx = rand_coord(span); q.cy = rand_coord(span);
        case ($urandom_range(0, 5))
            0: begin q.bx = q.ax; q.by = q.ay; end
            1: begin q.bx = CW'(q.ax + $signed(CW'($urandom_range(0, 2000))) - 1000);
                     q.by = CW'(q.ay + $signed(CW'($urandom_range(0, 2000))) - 1000); end
            default: begin q.bx = rand_coord(span); q.by = rand_coord(span); end
        endcase
        // pull the centre near the segment so the projection cases show up
        if ($urandom_range(0, 2) != 0)
        begin
            tx = (q.ax >>> 1) + (q.bx >>> 1);
            ty = (q.ay >>> 1) + (q.by >>> 1);
            q.cx = CW'(tx + $signed(CW'($urandom_range(0, 600))) - 300);
            q.cy = CW'(ty + $signed(CW'($urandom_range(0, 600))) - 300);
        end
        case ($urandom_range(0, 3))
            0: q.r = (CW-1)'($urandom());
            1: q.r = (CW-1)'($urandom_range(0, 400));
            default: q.r = (CW-1)'($urandom_range(0, 2 * span));
        endcase
        return q;
    endfunction

    task automatic drain();
        while (pending_queries.size() > 0 || expected_kinds.size() > 0 || start)
            @(posedge clk);
        repeat (LATENCY + 3) @(posedge clk);
    endtask

    task automatic write_tolerance(logic [TOL_WIDTH-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tolerance = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push(logic signed [CW-1:0] ax, ay, bx, by, cx, cy, logic [CW-2:0] r);
        query_t q;
        q.ax = ax; q.ay = ay; q.bx = bx; q.by = by; q.cx = cx; q.cy = cy; q.r = r;
        pending_queries.push_back(q);
    endtask

    initial
    begin
        logic [TOL_WIDTH-1:0] tol_settings[5];
        tol_settings = '{16'd0, 16'd26, 16'd1, 16'd300, 16'hffff};
        tolerance = 16'd26;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed corners at reset tolerance
        push(0, 0, 0, 0, 0, 0, 0);
        push(0, 0, 0, 0, 1000, 0, 500);
        push(0, 0, 0, 0, 100, 0, 100);
        push(0, 0, 2560, 0, 100, 0, 200);
        push(-2560, 0, 2560, 0, 0, 512, 512);
        push(-2560, 0, 2560, 0, 0, 513, 512);
        push(-2560, 0, 2560, 0, 0, 600, 512);
        push(0, 0, 2560, 0, 2572, 100, 200);
        push(0, 0, 2560, 0, 2574, 100, 200);
        push(0, 0, 2560, 0, -13, 100, 200);
        push(CMIN, CMIN, CMAX, CMAX, 0, 0, RMAX);
        push(CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, RMAX);
        push(CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, RMAX);
        push(CMIN, CMIN, CMAX, CMIN, 0, CMAX, RMAX);
        push(CMAX, CMAX, CMIN, CMIN, CMAX, CMIN, 0);
        push(-24'sh1, 24'sh555555, -24'sh2aaaab, 24'sh0, 24'sh2aaaaa, -24'sh555556, 23'h2aaaaa);
        drain();

        foreach (tol_settings[s])
        begin
            write_tolerance(tol_settings[s]);
            push(0, 0, 2560, 0, CW'(2560 + int'(tol_settings[s]) / 2), 10, 200);
            push(0, 0, 2560, 0, CW'(-(int'(tol_settings[s]) / 2) - 1), 10, 200);
            for (int i = 0; i < NUM_RANDOM / 5; i++)
            begin
                pending_queries.push_back(random_query());
                // one mid-phase stop until everything has drained
                if (i == 150)
                begin
                    while (pending_queries.size() > 0 || start)
                        @(posedge clk);
                    hold_off = 1'b1;
                    while (expected_kinds.size() > 0)
                        @(posedge clk);
                    hold_off = 1'b0;
                end
            end
            drain();
        end

        $display("queries checked: %0d no hit, %0d endpoint inside, %0d nearest point within radius",
                 kind_seen[0], kind_seen[1], kind_seen[2]);
        $display("tolerance settings covered: 0, 1, 26, 300, 65535");
        if (errors == 0)
            $display("segment_circle_intersect_top test passed");
        else
            $display("segment_circle_intersect_top test failed");
        $finish;
    end
endmodule
